// ===== hw/rtl/bmorph_pkg.sv =====
// ----------------------------------------------------------------------------
// bmorph_pkg
// Shared widths, register indexes, operation codes, size limits and reset
// dimensions of the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmorph_pkg;

  // configuration field widths
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION    = 2'd2;

  // operation codes
  localparam logic OP_DILATE = 1'b0;
  localparam logic OP_ERODE  = 1'b1;

  // size limits and reset dimensions
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_RESET      = 1024;

endpackage

`default_nettype wire

// ===== hw/rtl/bmorph_if.sv =====
// ----------------------------------------------------------------------------
// bmorph interfaces
// Valid/ready channels of the morphology block: configuration writes,
// input pixel requests and result requests.
// ----------------------------------------------------------------------------
`default_nettype none

// configuration write channel
interface bmorph_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bmorph_pkg::CFG_IDX_W-1:0] index;
  logic [bmorph_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// input pixel channel
interface bmorph_pix_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic drain;

  modport source (output valid, pixel_in, drain, input ready);
  modport sink   (input valid, pixel_in, drain, output ready);
endinterface

// result channel
interface bmorph_pix_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic frame_last;

  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/binary_morphology_3x3.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// Streaming 3x3 binary dilation / erosion of a raster-order 1-bit mask.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  writes image width, image height and operation (dilate/erode);
//          always ready, write only while the block is idle. Any write to a
//          listed register restarts the frame.
//   pix_i  takes one raster pixel per request; a drain request after the
//          last pixel of the frame pushes out one pending result.
//   res_o  gives one result per request, frame_last on the frame's last one.
// The result of pixel (x,y) is caused by the request of pixel (x+1,y+1) in
// raster order (or by a drain request near frame end) and reaches res_o
// through the read stage (line memory read) and then the window and the
// output register.
// Throughput is one request per clock while res_o takes results, set by the
// read-modify-write of the line memory; a one-column image forwards the
// word being written around the memory.
// Reset: counters clear, 1024x1024 (capped by MAX_WIDTH/MAX_HEIGHT), dilate.
// The line memory needs no clearing. When res_o stalls, one more request is
// taken into the read stage, then pix_i.ready drops until res_o frees.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_morphology_3x3 #(
  parameter int MAX_WIDTH  = bmorph_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmorph_pkg::MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmorph_cfg_if.sink       cfg_i,
  bmorph_pix_in_if.sink    pix_i,
  bmorph_pix_out_if.source res_o
);

  localparam int ColW      = $clog2(MAX_WIDTH);
  localparam int RowW      = $clog2(MAX_HEIGHT);
  localparam int RowCntW   = $clog2(MAX_HEIGHT + 1);
  localparam int WidthRst  = (bmorph_pkg::DIM_RESET > MAX_WIDTH) ?
                             MAX_WIDTH : bmorph_pkg::DIM_RESET;
  localparam int HeightRst = (bmorph_pkg::DIM_RESET > MAX_HEIGHT) ?
                             MAX_HEIGHT : bmorph_pkg::DIM_RESET;

  // one column of the window: [0] row above, [1] middle row, [2] row below
  typedef logic [2:0] col_t;

  // control and payload of the memory read stage
  typedef struct packed {
    logic            pix;
    logic [ColW-1:0] col;
    logic            emit;
    logic            last;
    logic            fwd;
    logic            first;
    logic            left_ok;
    logic            right_ok;
    logic            top_ok;
    logic            bot_ok;
  } s1_t;

  // configuration registers (stored as last index)
  logic [ColW-1:0] wlast_q, wlast_d;
  logic [RowW-1:0] hlast_q, hlast_d;
  logic            op_q;
  logic            cfg_we;
  logic            cfg_hit;
  logic [31:0]     cfg_val;

  // frame position counters
  logic [ColW-1:0]    in_col_q, in_col_d;
  logic [RowCntW-1:0] in_row_q, in_row_d;
  logic [ColW-1:0]    out_x_q, out_x_d;
  logic [RowW-1:0]    out_y_q, out_y_d;

  // handshake and request decode
  logic in_ready;
  logic pix_acc;
  logic out_free;
  logic frame_full;
  logic past_lag;
  logic col_last;
  logic ox_last;
  logic oy_last;
  logic acc_write;
  logic acc_emit;
  logic acc_last;

  // read stage
  logic       s1_valid_q;
  s1_t        s1_q, s1_d;
  logic       s1_proc;
  logic [1:0] rd_q;
  logic       first_pix_q;

  // window and result
  col_t       win_l_q, win_c_q;
  col_t       new_col, c_col, row_msk;
  logic       rd_prev, rd_prev2;
  logic [8:0] wnd, msk;
  logic       res_bit;
  logic [1:0] wr_word;
  logic       out_valid_q;
  logic       res_pix_q, res_last_q;

  // line memory: {row two above, row above} per column
  logic [1:0] line_mem [MAX_WIDTH];

  // configuration decode and clamping
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cfg_val     = 32'(cfg_i.data);
  assign cfg_hit     = cfg_we && (cfg_i.index == bmorph_pkg::CFG_IMAGE_WIDTH  ||
                                  cfg_i.index == bmorph_pkg::CFG_IMAGE_HEIGHT ||
                                  cfg_i.index == bmorph_pkg::CFG_OPERATION);

  always_comb begin
    if (cfg_val == 32'd0) begin
      wlast_d = '0;
    end else if (cfg_val > 32'(MAX_WIDTH)) begin
      wlast_d = ColW'(MAX_WIDTH - 1);
    end else begin
      wlast_d = ColW'(cfg_val - 32'd1);
    end
    if (cfg_val == 32'd0) begin
      hlast_d = '0;
    end else if (cfg_val > 32'(MAX_HEIGHT)) begin
      hlast_d = RowW'(MAX_HEIGHT - 1);
    end else begin
      hlast_d = RowW'(cfg_val - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= ColW'(WidthRst - 1);
      hlast_q <= RowW'(HeightRst - 1);
      op_q    <= bmorph_pkg::OP_DILATE;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        bmorph_pkg::CFG_IMAGE_WIDTH:  wlast_q <= wlast_d;
        bmorph_pkg::CFG_IMAGE_HEIGHT: hlast_q <= hlast_d;
        bmorph_pkg::CFG_OPERATION:    op_q    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_proc     = s1_valid_q && (!s1_q.emit || out_free);
  assign in_ready    = !s1_valid_q || s1_proc;
  assign pix_i.ready = in_ready;
  assign pix_acc     = pix_i.valid && in_ready;

  // request decode: write, result and frame end
  assign frame_full = in_row_q > RowCntW'(hlast_q);
  assign past_lag   = (in_row_q != '0) &&
                      !((in_row_q == RowCntW'(1)) && (in_col_q == '0));
  assign col_last   = in_col_q == wlast_q;
  assign ox_last    = out_x_q == wlast_q;
  assign oy_last    = out_y_q == hlast_q;
  assign acc_write  = pix_acc && (frame_full || !pix_i.drain);
  assign acc_emit   = pix_acc && (frame_full || (!pix_i.drain && past_lag));
  assign acc_last   = acc_emit && ox_last && oy_last;

  // position counters
  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    out_x_d  = out_x_q;
    out_y_d  = out_y_q;
    priority if (cfg_hit || acc_last) begin
      in_col_d = '0;
      in_row_d = '0;
      out_x_d  = '0;
      out_y_d  = '0;
    end else begin
      if (acc_write) begin
        // single-row frame: drain reads start one column ahead
        if (!col_last) begin
          in_col_d = in_col_q + 1'b1;
        end else if (!frame_full && hlast_q == '0 && wlast_q != '0) begin
          in_col_d = ColW'(1);
        end else begin
          in_col_d = '0;
        end
        if (col_last && !frame_full) begin
          in_row_d = in_row_q + 1'b1;
        end
      end
      if (acc_emit) begin
        if (ox_last) begin
          out_x_d = '0;
          out_y_d = out_y_q + 1'b1;
        end else begin
          out_x_d = out_x_q + 1'b1;
        end
      end
    end
  end

  // read stage contents
  always_comb begin
    s1_d.pix      = !frame_full && pix_i.pixel_in;
    s1_d.col      = in_col_q;
    s1_d.emit     = acc_emit;
    s1_d.last     = acc_last;
    s1_d.fwd      = s1_proc && (s1_q.col == in_col_q);
    s1_d.first    = acc_emit && (hlast_q == '0) && (out_x_q == '0);
    s1_d.left_ok  = out_x_q != '0;
    s1_d.right_ok = !ox_last;
    s1_d.top_ok   = out_y_q != '0;
    s1_d.bot_ok   = !oy_last;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      out_x_q  <= out_x_d;
      out_y_q  <= out_y_d;
      if (in_ready) begin
        s1_valid_q <= acc_write;
      end
      if (s1_proc && s1_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line memory: write back from the read stage, read for the new request
  always_ff @(posedge clk_i) begin
    if (s1_proc) begin
      line_mem[s1_q.col] <= wr_word;
    end
    if (acc_write) begin
      rd_q <= line_mem[in_col_q];
    end
  end

  // column read, with forwarding of the word written in the same cycle
  assign rd_prev  = s1_q.fwd ? win_c_q[2] : rd_q[0];
  assign rd_prev2 = s1_q.fwd ? win_c_q[1] : rd_q[1];
  assign new_col  = {s1_q.pix, rd_prev, rd_prev2};
  assign wr_word  = {rd_prev, s1_q.pix};
  assign c_col    = s1_q.first ? {1'b0, first_pix_q, 1'b0} : win_c_q;

  // neighbourhood with edge masking
  assign row_msk = {s1_q.bot_ok, 1'b1, s1_q.top_ok};
  assign wnd     = {new_col, c_col, win_l_q};
  assign msk     = {row_msk & {3{s1_q.right_ok}}, row_msk, row_msk & {3{s1_q.left_ok}}};

  always_comb begin
    unique case (op_q)
      bmorph_pkg::OP_DILATE: res_bit = |(wnd & msk);
      bmorph_pkg::OP_ERODE:  res_bit = &(wnd | ~msk);
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_write) begin
      s1_q <= s1_d;
    end
    if (acc_write && !frame_full && in_row_q == '0 && in_col_q == '0) begin
      first_pix_q <= pix_i.pixel_in;
    end
    if (s1_proc) begin
      win_l_q <= c_col;
      win_c_q <= new_col;
    end
    if (s1_proc && s1_q.emit) begin
      res_pix_q  <= res_bit;
      res_last_q <= s1_q.last;
    end
  end

  // result channel
  assign res_o.valid      = out_valid_q;
  assign res_o.pixel_out  = res_pix_q;
  assign res_o.frame_last = res_last_q;

  // column and result position counters stay inside the configured frame
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_col_q <= wlast_q) && (out_x_q <= wlast_q) && (out_y_q <= hlast_q))
    else $error("frame counter beyond configured size");

  // the last result of a frame restarts all counters
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && acc_last) |=>
      (in_row_q == '0) && (in_col_q == '0) && (out_x_q == '0) && (out_y_q == '0))
    else $error("counters not restarted after frame end");

  // no result while the first row is still arriving
  a_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && acc_emit) |-> (in_row_q != '0))
    else $error("result issued within the first row");

endmodule

`default_nettype wire

// ===== sim/binary_morphology_3x3_test.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_3x3_test
// Self-checking testbench of the streaming 3x3 dilation / erosion block. A
// queue of pixel requests feeds a clocked driver with random gaps. A clocked
// monitor stalls the result side at random and keeps its own copy of the line
// stores, counters and registers. It compares every result request with the
// oldest predicted one. Frames run from a single pixel up to the widest and
// tallest sizes, with register values outside the legal range, ignored drains,
// pixels that only flush, and frames abandoned by a register write.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_morphology_3x3_test;
  import bmorph_pkg::*;

  localparam int LINE_LEN      = MAX_WIDTH_DEF;
  localparam int ROWS_MAX      = MAX_HEIGHT_DEF;
  localparam int RANDOM_ITEMS  = 450;
  localparam int MAX_WAIT      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int PRINT_LIMIT   = 100;

  // register index past the end of the list, writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 2'd3;

  typedef struct packed {
    logic pixel;
    logic drain;
    logic hold;
  } pixel_request_t;

  typedef struct packed {
    logic pixel;
    logic last;
  } morph_result_t;

  logic clk_i;
  logic rst_ni;

  bmorph_cfg_if     cfg_if ();
  bmorph_pix_in_if  pix_if ();
  bmorph_pix_out_if res_if ();

  binary_morphology_3x3 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  // pending pixel requests and predicted results
  pixel_request_t pixel_requests[$];
  morph_result_t  expected_results[$];

  // mirror of the block state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             op_reg;
  logic             mask_rows [4][LINE_LEN];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      result_pos;

  // run control and statistics
  bit          steady_flow;
  logic        results_outstanding;
  int unsigned gap_left;
  bit          gap_drawn;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned error_count;
  int unsigned requests_taken;
  int unsigned results_checked;
  int unsigned frames_closed;
  int unsigned writes_taken;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic void restart_frame();
    col_pos    = 0;
    row_pos    = 0;
    result_pos = 0;
  endfunction

  function automatic void reset_mirror();
    width_reg  = DIM_W'(DIM_RESET);
    height_reg = DIM_W'(DIM_RESET);
    op_reg     = OP_DILATE;
    foreach (mask_rows[r, c]) mask_rows[r][c] = 1'b0;
    restart_frame();
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = value;
      CFG_IMAGE_HEIGHT: height_reg = value;
      CFG_OPERATION:    op_reg = value[0];
      default: return;
    endcase
    restart_frame();
  endfunction

  // 3x3 neighborhood of (ox,oy); erosion works on the complement, so pixels
  // outside the frame count as clear for dilation and as set for erosion
  function automatic logic window_value(int unsigned ox, int unsigned oy,
                                        int unsigned w, int unsigned h);
    int   xx;
    int   yy;
    logic any_set;
    any_set = 1'b0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        yy = int'(oy) + dy;
        xx = int'(ox) + dx;
        if (yy >= 0 && xx >= 0 && yy < int'(h) && xx < int'(w))
          any_set |= mask_rows[yy % 4][xx] ^ (op_reg == OP_ERODE);
      end
    end
    return (op_reg == OP_ERODE) ? ~any_set : any_set;
  endfunction

  function automatic void take_request(logic pixel, logic drain);
    int unsigned   w;
    int unsigned   h;
    int unsigned   total;
    int unsigned   written;
    morph_result_t res;
    w     = clamp_dim(width_reg, LINE_LEN);
    h     = clamp_dim(height_reg, ROWS_MAX);
    total = w * h;
    // frame still arriving: store the pixel, a drain does nothing yet
    if (row_pos < h) begin
      if (drain) return;
      mask_rows[row_pos % 4][col_pos] = pixel;
      written = row_pos * w + col_pos;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (written < w + 1) return;
    end
    if (result_pos >= total) begin
      restart_frame();
      return;
    end
    res.pixel = window_value(result_pos % w, result_pos / w, w, h);
    result_pos++;
    res.last = (result_pos >= total);
    if (res.last) restart_frame();
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what);
    // keep the log short when a bug hits every result
    if (error_count < PRINT_LIMIT)
      $display("[%0t] result %0d: %s", $time, results_checked, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // pixel request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : pixel_source
    logic presenting;
    logic accepted_now;
    if (!rst_ni) begin
      pix_if.valid    <= 1'b0;
      pix_if.pixel_in <= 1'b0;
      pix_if.drain    <= 1'b0;
      gap_left  = 0;
      gap_drawn = 1'b0;
    end else begin
      accepted_now = pix_if.valid && pix_if.ready;
      presenting   = pix_if.valid && !accepted_now;
      if (!presenting && pixel_requests.size() != 0) begin
        if (!gap_drawn) begin
          gap_left  = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
          gap_drawn = 1'b1;
        end
        // a held request waits until every predicted result has left
        if (gap_left != 0) begin
          gap_left--;
        end else if (!pixel_requests[0].hold || (!results_outstanding && !accepted_now)) begin
          pix_if.pixel_in <= pixel_requests[0].pixel;
          pix_if.drain    <= pixel_requests[0].drain;
          void'(pixel_requests.pop_front());
          presenting = 1'b1;
          gap_drawn  = 1'b0;
        end
      end
      pix_if.valid <= presenting;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor, predictor update and result stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    morph_result_t want;
    if (!rst_ni) begin
      res_if.ready        <= 1'b0;
      results_outstanding <= 1'b0;
      stall_left = 0;
    end else begin
      // check results before predicting from this edge's pixel request
      if (res_if.valid && res_if.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel_out=%b frame_last=%b",
                                    res_if.pixel_out, res_if.frame_last));
        end else begin
          want = expected_results.pop_front();
          if (res_if.pixel_out !== want.pixel)
            report_mismatch($sformatf("pixel_out %b, expected %b", res_if.pixel_out, want.pixel));
          if (res_if.frame_last !== want.last)
            report_mismatch($sformatf("frame_last %b, expected %b",
                                      res_if.frame_last, want.last));
          if (want.last) frames_closed++;
        end
        stall_left = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (pix_if.valid && pix_if.ready) begin
        requests_taken++;
        take_request(pix_if.pixel_in, pix_if.drain);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        writes_taken++;
        apply_register(cfg_if.index, cfg_if.data);
      end
      res_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
      results_outstanding <= (expected_results.size() != 0);
    end
  end

  // watchdog on requests of any channel
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no request moved for %0d cycles, %0d results still expected",
               quiet_cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_request(logic pixel, logic drain, logic hold);
    pixel_request_t rq;
    rq.pixel = pixel;
    rq.drain = drain;
    rq.hold  = hold;
    pixel_requests.push_back(rq);
  endfunction

  // one frame of w*h pixels and its flush, or only a leading part of it;
  // returns the number of requests that carry a pixel or flush a result
  function automatic int unsigned queue_frame(int unsigned w, int unsigned h,
                                              int unsigned density, bit noisy, bit broken);
    int unsigned n_pix;
    int unsigned flush;
    int unsigned queued;
    n_pix  = broken ? $urandom_range(0, w * h - 1) : w * h;
    flush  = (w * h < w + 1) ? w * h : w + 1;
    queued = 0;
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(0, 15) == 0)
        push_request(1'($urandom_range(0, 1)), 1'b1, 1'b0);
      push_request($urandom_range(0, 99) < density, 1'b0, $urandom_range(0, 39) == 0);
      queued++;
    end
    if (!broken) begin
      // noisy flushes mix drains with pixels whose bit is dropped
      for (int unsigned i = 0; i < flush; i++) begin
        push_request(1'($urandom_range(0, 1)), noisy ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0);
        queued++;
      end
      if (noisy && $urandom_range(0, 3) == 0)
        push_request(1'($urandom_range(0, 1)), 1'b1, 1'b0);
    end
    return queued;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(2);
      default: return DIM_W'($urandom_range(3, 9));
    endcase
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // all three registers, starting at a random one of the fixed order; operation carries random upper bits
  task automatic configure(logic [DIM_W-1:0] width_raw, logic [DIM_W-1:0] height_raw,
                           logic op);
    logic [CFG_IDX_W-1:0] order [3];
    logic [DIM_W-1:0]     op_word;
    int unsigned          first;
    order   = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_OPERATION};
    first   = $urandom_range(0, 2);
    op_word = DIM_W'($urandom);
    op_word[0] = op;
    for (int k = 0; k < 3; k++) begin
      case (order[(first + k) % 3])
        CFG_IMAGE_WIDTH:  write_register(CFG_IMAGE_WIDTH, width_raw);
        CFG_IMAGE_HEIGHT: write_register(CFG_IMAGE_HEIGHT, height_raw);
        default:          write_register(CFG_OPERATION, op_word);
      endcase
    end
  endtask

  // until the driver is empty and every result is in, then let the pipeline drain
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_requests.size() != 0 || pix_if.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [DIM_W-1:0] width_raw, logic [DIM_W-1:0] height_raw,
                           logic op, int unsigned frames, output int unsigned queued);
    int unsigned w;
    int unsigned h;
    int unsigned density;
    bit          broken;
    configure(width_raw, height_raw, op);
    w = clamp_dim(width_raw, LINE_LEN);
    h = clamp_dim(height_raw, ROWS_MAX);
    if ($urandom_range(0, 2) == 0) density = 50;
    else density = $urandom_range(0, 1) ? 10 : 90;
    queued = 0;
    @(negedge clk_i);
    steady_flow = ($urandom_range(0, 3) == 0);
    for (int unsigned f = 0; f < frames; f++) begin
      // a cut frame only ever ends a phase, the next write abandons it
      broken  = (frames > 1) && (f == frames - 1) && ($urandom_range(0, 3) == 0);
      queued += queue_frame(w, h, density, $urandom_range(0, 2) == 0, broken);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_queued;
    int unsigned queued;
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    steady_flow   = 1'b0;
    reset_mirror();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-pixel frame: early drain ignored, a pixel after the end flushes
    write_register(CFG_UNLISTED, '1);
    configure(DIM_W'(1), DIM_W'(1), OP_DILATE);
    @(negedge clk_i);
    push_request(1'b1, 1'b1, 1'b0);
    push_request(1'b1, 1'b0, 1'b0);
    push_request(1'b0, 1'b0, 1'b0);
    push_request(1'b0, 1'b1, 1'b0);
    wait_idle();

    // 3x3 erosion, unlisted register written mid-frame must not restart it
    configure(DIM_W'(3), DIM_W'(3), OP_ERODE);
    @(negedge clk_i);
    repeat (5) push_request(1'b1, 1'b0, 1'b0);
    wait_idle();
    write_register(CFG_UNLISTED, DIM_W'(11'h555));
    @(negedge clk_i);
    push_request(1'b1, 1'b1, 1'b0);
    push_request(1'b1, 1'b0, 1'b0);
    push_request(1'b1, 1'b0, 1'b1);
    push_request(1'b1, 1'b0, 1'b0);
    push_request(1'b0, 1'b0, 1'b0);
    push_request(1'b0, 1'b1, 1'b0);
    push_request(1'b1, 1'b0, 1'b1);
    push_request(1'b0, 1'b1, 1'b0);
    push_request(1'b0, 1'b1, 1'b0);
    wait_idle();

    // random small frames, both operations, several frames per setting
    random_queued = 0;
    while (random_queued < RANDOM_ITEMS) begin
      run_phase(pick_dim(), pick_dim(), $urandom_range(0, 1) ? OP_ERODE : OP_DILATE,
                $urandom_range(1, 3), queued);
      random_queued += queued;
    end

    // widest and tallest frames, out-of-range values clamp
    run_phase(DIM_W'(11'h7ff), '0, OP_DILATE, 1, queued);
    run_phase(DIM_W'(1), DIM_W'(11'h7ff), OP_ERODE, 1, queued);
    run_phase(DIM_W'(1024), DIM_W'(2), OP_ERODE, 1, queued);
    run_phase('0, DIM_W'(1024), OP_DILATE, 1, queued);

    wait_idle();
    $display("%0d pixel requests, %0d results in %0d complete frames, %0d register writes",
             requests_taken, results_checked, frames_closed, writes_taken);
    $display("frames from 1x1 up to 1024 wide or tall, dilation and erosion, drains and flushes");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
